>>> src/zcwpt_pkg.sv
// ----------------------------------------------------------------------------
// zcwpt_pkg
// Types and constants for the zero-crossing weld pulse timer.
// ----------------------------------------------------------------------------
package zcwpt_pkg;

	localparam logic [1:0] FUNC_LOOP_TICK = 2'd0;
	localparam logic [1:0] FUNC_CROSSING  = 2'd1;
	localparam logic [1:0] FUNC_TIMEBASE  = 2'd2;

	localparam logic [1:0] REG_HOLDOFF_LENGTH  = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE_LENGTH = 2'd1;
	localparam logic [1:0] REG_BEEP_LENGTH     = 2'd2;
	localparam logic [1:0] REG_FIRE_DELAY      = 2'd3;

	localparam logic [15:0] HOLDOFF_LENGTH_RST  = 16'd100;
	localparam logic [7:0]  DEBOUNCE_LENGTH_RST = 8'd10;
	localparam logic [15:0] BEEP_LENGTH_RST     = 16'd1000;
	localparam logic [15:0] FIRE_DELAY_RST      = 16'd5701;
	localparam logic [4:0]  WELD_SETTING_RST    = 5'd10;

	localparam logic [5:0]  LED_DIVIDE = 6'd50;

	typedef struct packed {
		logic [1:0] func;
		logic       button_down;
		logic [7:0] knob_level;
	} item_t;

	typedef struct packed {
		logic       triac_on;
		logic       beep_on;
		logic       led_on;
		logic [5:0] half_cycles_left;
	} result_t;

endpackage

>>> src/zero_cross_weld_pulse_timer.sv
// ----------------------------------------------------------------------------
// zero_cross_weld_pulse_timer
// Mains-synchronised weld pulse timer: one event in, one level report out.
// ----------------------------------------------------------------------------
// Each accepted event (loop tick, zero crossing or timebase tick) updates the
// counters in the cycle it is accepted and yields one result from the result
// register in the cycle after. Sustains one event per clock; the only limit
// is the result register, which accepts a new event whenever it is empty or
// is being drained in the same cycle. Register writes take effect at the next
// reload of the counter using them; the debounce bound check sees them at once.
module zero_cross_weld_pulse_timer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  zcwpt_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output zcwpt_pkg::result_t result
);
	import zcwpt_pkg::*;

	logic [15:0] holdoff_length_q, beep_length_q, fire_delay_q;
	logic [7:0]  debounce_length_q;

	logic [15:0] holdoff_count_q, delay_count_q, beep_count_q;
	logic [5:0]  crossing_count_q, weld_left_q;
	logic [7:0]  debounce_count_q;
	logic [4:0]  weld_setting_q;
	logic        led_level_q, start_pending_q, delay_armed_q, triac_level_q, beep_level_q;

	logic [15:0] holdoff_count_d, delay_count_d, beep_count_d;
	logic [5:0]  crossing_count_d, weld_left_d, cross_inc;
	logic [7:0]  debounce_count_d;
	logic [4:0]  weld_setting_d;
	logic        led_level_d, start_pending_d, delay_armed_d, triac_level_d, beep_level_d;

	logic        result_valid_q;
	result_t     result_q;
	logic        take;

	assign item_ready   = !result_valid_q || result_ready;
	assign take         = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_length_q  <= HOLDOFF_LENGTH_RST;
			debounce_length_q <= DEBOUNCE_LENGTH_RST;
			beep_length_q     <= BEEP_LENGTH_RST;
			fire_delay_q      <= FIRE_DELAY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HOLDOFF_LENGTH:  holdoff_length_q  <= cfg_data;
				REG_DEBOUNCE_LENGTH: debounce_length_q <= cfg_data[7:0];
				REG_BEEP_LENGTH:     beep_length_q     <= cfg_data;
				REG_FIRE_DELAY:      fire_delay_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		holdoff_count_d  = holdoff_count_q;
		crossing_count_d = crossing_count_q;
		led_level_d      = led_level_q;
		start_pending_d  = start_pending_q;
		debounce_count_d = debounce_count_q;
		weld_setting_d   = weld_setting_q;
		weld_left_d      = weld_left_q;
		delay_count_d    = delay_count_q;
		delay_armed_d    = delay_armed_q;
		triac_level_d    = triac_level_q;
		beep_count_d     = beep_count_q;
		beep_level_d     = beep_level_q;
		cross_inc        = crossing_count_q + 6'd1;

		unique case (item.func)
			FUNC_LOOP_TICK: begin
				if (holdoff_count_q != 16'd0)
					holdoff_count_d = holdoff_count_q - 16'd1;
				weld_setting_d = item.knob_level[7:3];
				if (beep_count_q != 16'd0) begin
					beep_count_d = beep_count_q - 16'd1;
					beep_level_d = 1'b1;
				end else begin
					beep_level_d = 1'b0;
				end
			end
			FUNC_CROSSING: begin
				if (holdoff_count_q == 16'd0) begin
					holdoff_count_d = holdoff_length_q;
					if (cross_inc >= LED_DIVIDE) begin
						crossing_count_d = 6'd0;
						led_level_d      = !led_level_q;
					end else begin
						crossing_count_d = cross_inc;
					end
					if (start_pending_q) begin
						delay_count_d   = fire_delay_q;
						delay_armed_d   = 1'b1;
						weld_left_d     = {weld_setting_q, 1'b1};
						start_pending_d = 1'b0;
					end
					if (weld_left_d != 6'd0)
						weld_left_d = weld_left_d - 6'd1;
					if (weld_left_d == 6'd0)
						triac_level_d = 1'b0;
					if (!item.button_down) begin
						debounce_count_d = debounce_length_q;
					end else begin
						if (debounce_count_q <= debounce_length_q)
							debounce_count_d = debounce_count_q - 8'd1;
						if (debounce_count_d == 8'd0)
							start_pending_d = 1'b1;
					end
				end
			end
			FUNC_TIMEBASE: begin
				if (delay_armed_q) begin
					if (delay_count_q <= 16'd1) begin
						delay_count_d = 16'd0;
						delay_armed_d = 1'b0;
						triac_level_d = 1'b1;
						beep_count_d  = beep_length_q;
					end else begin
						delay_count_d = delay_count_q - 16'd1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_count_q  <= HOLDOFF_LENGTH_RST;
			crossing_count_q <= 6'd0;
			led_level_q      <= 1'b0;
			start_pending_q  <= 1'b0;
			debounce_count_q <= DEBOUNCE_LENGTH_RST;
			weld_setting_q   <= WELD_SETTING_RST;
			weld_left_q      <= 6'd0;
			delay_count_q    <= 16'd0;
			delay_armed_q    <= 1'b0;
			triac_level_q    <= 1'b0;
			beep_count_q     <= BEEP_LENGTH_RST;
			beep_level_q     <= 1'b0;
		end else if (take) begin
			holdoff_count_q  <= holdoff_count_d;
			crossing_count_q <= crossing_count_d;
			led_level_q      <= led_level_d;
			start_pending_q  <= start_pending_d;
			debounce_count_q <= debounce_count_d;
			weld_setting_q   <= weld_setting_d;
			weld_left_q      <= weld_left_d;
			delay_count_q    <= delay_count_d;
			delay_armed_q    <= delay_armed_d;
			triac_level_q    <= triac_level_d;
			beep_count_q     <= beep_count_d;
			beep_level_q     <= beep_level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q.triac_on         <= triac_level_d;
			result_q.beep_on          <= beep_level_d;
			result_q.led_on           <= led_level_d;
			result_q.half_cycles_left <= weld_left_d;
		end
	end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zero-crossing weld pulse timer. A behavioural
// tracker mirrors the counters and levels for every accepted event and holds
// the expected level reports in order; each report the block hands over is
// compared field by field. Directed events cover reset levels, ignored and
// unused events, zero fire delay, restarts and late firing. Random phases with
// different register settings and random idling on both sides follow.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import zcwpt_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PHASE_EVENTS = 75;

	typedef struct packed {
		logic [15:0] holdoff;
		logic [7:0]  debounce;
		logic [15:0] beep;
		logic [15:0] fire;
	} setting_t;

	class weld_level_tracker;
		logic [15:0] holdoff_len, beep_len, fire_len;
		logic [7:0]  debounce_len;
		logic [15:0] holdoff_cnt, delay_cnt, beep_cnt;
		logic [7:0]  debounce_cnt;
		logic [5:0]  crossing_cnt, weld_left;
		logic [4:0]  weld_setting;
		logic        led, start_pending, delay_armed, triac, beep;
		result_t     expected_levels[$];
		int          errors;
		int          checked;

		function new();
			holdoff_len = HOLDOFF_LENGTH_RST;
			debounce_len = DEBOUNCE_LENGTH_RST;
			beep_len = BEEP_LENGTH_RST;
			fire_len = FIRE_DELAY_RST;
			holdoff_cnt = HOLDOFF_LENGTH_RST;
			crossing_cnt = '0;
			led = 1'b0;
			start_pending = 1'b0;
			debounce_cnt = DEBOUNCE_LENGTH_RST;
			weld_setting = WELD_SETTING_RST;
			weld_left = '0;
			delay_cnt = '0;
			delay_armed = 1'b0;
			triac = 1'b0;
			beep_cnt = BEEP_LENGTH_RST;
			beep = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] value);
			case (idx)
				REG_HOLDOFF_LENGTH:  holdoff_len = value;
				REG_DEBOUNCE_LENGTH: debounce_len = value[7:0];
				REG_BEEP_LENGTH:     beep_len = value;
				REG_FIRE_DELAY:      fire_len = value;
				default: ;
			endcase
		endfunction

		function void take_event(item_t ev);
			result_t lv;
			case (ev.func)
				FUNC_LOOP_TICK: begin
					if (holdoff_cnt != '0)
						holdoff_cnt = holdoff_cnt - 16'd1;
					weld_setting = ev.knob_level[7:3];
					if (beep_cnt != '0) begin
						beep_cnt = beep_cnt - 16'd1;
						beep = 1'b1;
					end else begin
						beep = 1'b0;
					end
				end
				FUNC_CROSSING: begin
					if (holdoff_cnt == '0) begin
						holdoff_cnt = holdoff_len;
						crossing_cnt = crossing_cnt + 6'd1;
						if (crossing_cnt >= LED_DIVIDE) begin
							crossing_cnt = '0;
							led = ~led;
						end
						if (start_pending) begin
							delay_cnt = fire_len;
							delay_armed = 1'b1;
							weld_left = {weld_setting, 1'b1};
							start_pending = 1'b0;
						end
						if (weld_left != '0)
							weld_left = weld_left - 6'd1;
						if (weld_left == '0)
							triac = 1'b0;
						if (!ev.button_down) begin
							debounce_cnt = debounce_len;
						end else begin
							if (debounce_cnt <= debounce_len)
								debounce_cnt = debounce_cnt - 8'd1;
							if (debounce_cnt == '0)
								start_pending = 1'b1;
						end
					end
				end
				FUNC_TIMEBASE: begin
					if (delay_armed) begin
						if (delay_cnt <= 16'd1) begin
							delay_cnt = '0;
							delay_armed = 1'b0;
							triac = 1'b1;
							beep_cnt = beep_len;
						end else begin
							delay_cnt = delay_cnt - 16'd1;
						end
					end
				end
				default: ;
			endcase
			lv.triac_on = triac;
			lv.beep_on = beep;
			lv.led_on = led;
			lv.half_cycles_left = weld_left;
			expected_levels.push_back(lv);
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("levels mismatch at result %0d: %s got %0d expected %0d",
				checked, what, got, want);
			errors++;
		endtask

		task check_levels(result_t got);
			result_t want;
			checked++;
			if (expected_levels.size() == 0) begin
				report_mismatch("result with nothing pending", int'(got), 0);
				return;
			end
			want = expected_levels.pop_front();
			if (got.triac_on !== want.triac_on)
				report_mismatch("triac_on", int'(got.triac_on), int'(want.triac_on));
			if (got.beep_on !== want.beep_on)
				report_mismatch("beep_on", int'(got.beep_on), int'(want.beep_on));
			if (got.led_on !== want.led_on)
				report_mismatch("led_on", int'(got.led_on), int'(want.led_on));
			if (got.half_cycles_left !== want.half_cycles_left)
				report_mismatch("half_cycles_left", int'(got.half_cycles_left),
					int'(want.half_cycles_left));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;

	logic tx_idle;
	logic rx_idle;
	int   hold_requests;
	int   cycle_count;

	weld_level_tracker levels;

	zero_cross_weld_pulse_timer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				levels.check_levels(result);
			if (item_valid && item_ready)
				levels.take_event(item);
		end
	end

	task automatic send_event(logic [1:0] func, logic button, logic [7:0] knob);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{func: func, button_down: button, knob_level: knob};
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (levels.expected_levels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		levels.set_reg(idx, value);
	endtask

	task automatic program_regs(setting_t s);
		write_reg(REG_HOLDOFF_LENGTH, s.holdoff);
		write_reg(REG_DEBOUNCE_LENGTH, {8'd0, s.debounce});
		write_reg(REG_BEEP_LENGTH, s.beep);
		write_reg(REG_FIRE_DELAY, s.fire);
		cfg_wr_en <= 1'b0;
	endtask

	// receiving side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		int holds_served;
		holds_served = 0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 3) : 0;
			if (hold_requests != holds_served) begin
				holds_served++;
				stall = LONG_HOLD_CYCLES;
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		setting_t   plan [0:PHASES-1];
		logic       btn;
		logic [1:0] fn;
		int         r;
		levels = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_HOLDOFF_LENGTH;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_requests = 0;
		plan = '{
			'{16'd0,     8'd1,   16'd4,     16'd1},
			'{16'd1,     8'd2,   16'd12,    16'd3},
			'{16'd0,     8'd3,   16'd0,     16'd2},
			'{16'd2,     8'd0,   16'd65535, 16'd1},
			'{16'd0,     8'd255, 16'd1,     16'd0},
			'{16'd1,     8'd254, 16'd7,     16'd65535},
			'{16'd0,     8'd1,   16'd3,     16'd2},
			'{16'd65535, 8'd2,   16'd5,     16'd5}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels: unused code, idle timebase, crossing inside holdoff
		send_event(FUNC_UNUSED, 1'b1, 8'hFF);
		send_event(FUNC_TIMEBASE, 1'b0, 8'h00);
		send_event(FUNC_CROSSING, 1'b1, 8'h00);
		send_event(FUNC_LOOP_TICK, 1'b0, 8'hFF);
		send_event(FUNC_LOOP_TICK, 1'b1, 8'h00);
		settle();

		program_regs('{16'd0, 8'd1, 16'd2, 16'd0});
		// longest weld, zero fire delay, beep run-out
		send_event(FUNC_LOOP_TICK, 1'b0, 8'hFF);
		send_event(FUNC_CROSSING, 1'b0, 8'h00);
		send_event(FUNC_CROSSING, 1'b1, 8'h00);
		send_event(FUNC_CROSSING, 1'b1, 8'h00);
		send_event(FUNC_TIMEBASE, 1'b0, 8'h00);
		repeat (3) send_event(FUNC_LOOP_TICK, 1'b0, 8'h00);
		// restart during a weld
		send_event(FUNC_CROSSING, 1'b0, 8'h00);
		send_event(FUNC_CROSSING, 1'b1, 8'h00);
		send_event(FUNC_LOOP_TICK, 1'b0, 8'h18);
		send_event(FUNC_CROSSING, 1'b1, 8'h00);
		send_event(FUNC_TIMEBASE, 1'b1, 8'h00);
		// firing after the weld count has ended
		send_event(FUNC_LOOP_TICK, 1'b0, 8'h00);
		send_event(FUNC_CROSSING, 1'b0, 8'h00);
		send_event(FUNC_CROSSING, 1'b1, 8'h00);
		send_event(FUNC_CROSSING, 1'b1, 8'h00);
		send_event(FUNC_TIMEBASE, 1'b0, 8'h00);
		send_event(FUNC_CROSSING, 1'b0, 8'h00);
		send_event(FUNC_TIMEBASE, 1'b0, 8'h00);
		send_event(FUNC_UNUSED, 1'b0, 8'h00);
		settle();

		btn = 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			program_regs(plan[p]);
			tx_idle = (p == 2) ? 1'b0 : $urandom_range(0, 3) != 0;
			rx_idle = (p == 2) ? 1'b0 : $urandom_range(0, 3) != 0;
			if (p == 1 || p == 4)
				hold_requests++;
			repeat (PHASE_EVENTS) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					fn = FUNC_LOOP_TICK;
				else if (r < 68)
					fn = FUNC_CROSSING;
				else if (r < 95)
					fn = FUNC_TIMEBASE;
				else
					fn = FUNC_UNUSED;
				// hold the button across several crossings
				if ($urandom_range(0, 11) == 0)
					btn = ~btn;
				send_event(fn, btn, 8'($urandom_range(0, 255)));
			end
			settle();
		end

		if (levels.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
src/zcwpt_pkg.sv
src/zero_cross_weld_pulse_timer.sv
tb/tb_top.sv
